[rtl/tprf_pkg.sv]
// tprf_pkg: shared constants and control types for the temporal radius filter
// used by tprf_ctrl, tprf_dp and temporal_point_cloud_radius_filter_top
package tprf_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;

  localparam int FRAME_W  = 32;
  localparam int THR_W    = 16;
  localparam int KEPT_W   = 11;
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int RAM_AW   = ADDR_W + 1;
  localparam int RAM_DEPTH = 2 * (1 << ADDR_W);
  localparam int PT_W     = 3 * COORD_BITS;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int SUM_W    = SQ_W + 2;
  localparam int LIMIT_W  = 2 * THR_W;
  localparam int COUNT_CAP = (MAX_POINTS < 2047) ? MAX_POINTS : 2047;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(256);

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic accept;
    logic scan;
    logic emit_keep;
    logic emit_sum;
  } tprf_cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic scan_done;
    logic hit;
    logic out_free;
  } tprf_stat_t;

endpackage

[rtl/tprf_ram.sv]
// tprf_ram: generic one-write one-read ram with registered read data
// no dependencies
module tprf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/tprf_ctrl.sv]
// tprf_ctrl: sequencing state machine for the radius filter
// depends on tprf_pkg; drives commands to tprf_dp
module tprf_ctrl
  import tprf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_stall,
  input  tprf_stat_t stat,
  output tprf_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_KEEP,
    S_SUM
  } state_t;

  state_t state_r;
  logic   idle;

  assign idle     = (state_r == S_IDLE);
  assign in_stall = !idle;

  always_comb begin
    cmd           = '0;
    cmd.accept    = idle && in_valid;
    cmd.scan      = (state_r == S_SCAN);
    cmd.emit_keep = (state_r == S_KEEP) && stat.out_free;
    cmd.emit_sum  = (state_r == S_SUM) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_kind == KIND_END) begin
              state_r <= S_SUM;
            end else if (stat.scan_needed) begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (stat.scan_done) begin
            state_r <= stat.hit ? S_KEEP : S_IDLE;
          end
        end
        S_KEEP: begin
          if (stat.out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_SUM: begin
          if (stat.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/tprf_dp.sv]
// tprf_dp: frame bookkeeping, point store, distance pipeline and output register
// depends on tprf_pkg and tprf_ram; controlled by tprf_ctrl
module tprf_dp
  import tprf_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  tprf_cmd_t                    cmd,
  output tprf_stat_t                   stat,
  input  logic                         cfg_valid,
  input  logic [THR_W-1:0]             cfg_data,
  input  logic                         in_kind,
  input  logic signed [FRAME_W-1:0]    in_frame_id,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic                         out_is_summary,
  output logic signed [COORD_BITS-1:0] out_kept_x,
  output logic signed [COORD_BITS-1:0] out_kept_y,
  output logic signed [COORD_BITS-1:0] out_kept_z,
  output logic [KEPT_W-1:0]            out_kept_count,
  output logic                         out_overflow,
  output logic                         out_last
);

  logic [THR_W-1:0]   thr_r;
  logic [LIMIT_W-1:0] limit_r;

  logic               ref_bank_r;
  logic [CNT_W-1:0]   ref_count_r;
  logic [CNT_W-1:0]   inc_count_r;
  logic [KEPT_W-1:0]  passed_r;
  logic               ref_valid_r;
  logic [FRAME_W-1:0] ref_frame_r;
  logic               frame_open_r;
  logic               filt_r;
  logic               ovf_r;

  logic signed [COORD_BITS-1:0] pt_x_r, pt_y_r, pt_z_r;

  logic [CNT_W-1:0]   scan_idx_r;
  logic               rd_vld_r;
  logic               sq_vld_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r, sqz_r;
  logic               hit_r;

  logic               out_valid_r;
  logic               out_sum_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r, out_z_r;
  logic [KEPT_W-1:0]  out_cnt_r;
  logic               out_ovf_r;

  logic [FRAME_W-1:0] frame_diff;
  logic               filt_eff;
  logic [CNT_W-1:0]   inc_eff;
  logic               store_ok;
  logic               wr_en;
  logic               issue;
  logic [PT_W-1:0]    rd_data;
  logic signed [COORD_BITS-1:0] rx, ry, rz;
  logic signed [DIFF_W-1:0]     dx, dy, dz;
  logic signed [2*DIFF_W-1:0]   px, py, pz;
  logic [SUM_W-1:0]   dist_sum;
  logic               out_free;
  logic [KEPT_W-1:0]  passed_nxt;

  assign frame_diff = FRAME_W'(in_frame_id) - ref_frame_r;
  assign filt_eff   = frame_open_r ? filt_r : (ref_valid_r && !frame_diff[FRAME_W-1]);
  assign inc_eff    = frame_open_r ? inc_count_r : '0;
  assign store_ok   = (inc_eff < CNT_W'(MAX_POINTS));
  assign wr_en      = cmd.accept && (in_kind == KIND_POINT) && store_ok;
  assign issue      = cmd.scan && !hit_r && (scan_idx_r < ref_count_r);
  assign out_free   = !out_valid_r || !out_stall;

  tprf_ram #(
    .WIDTH (PT_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({~ref_bank_r, inc_eff[ADDR_W-1:0]}),
    .wr_data ({in_point_x, in_point_y, in_point_z}),
    .rd_en   (issue),
    .rd_addr ({ref_bank_r, scan_idx_r[ADDR_W-1:0]}),
    .rd_data (rd_data)
  );

  assign rx = rd_data[3*COORD_BITS-1:2*COORD_BITS];
  assign ry = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rz = rd_data[COORD_BITS-1:0];

  assign dx = DIFF_W'(pt_x_r) - DIFF_W'(rx);
  assign dy = DIFF_W'(pt_y_r) - DIFF_W'(ry);
  assign dz = DIFF_W'(pt_z_r) - DIFF_W'(rz);
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  assign dist_sum = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);

  assign passed_nxt = (passed_r < KEPT_W'(COUNT_CAP)) ? passed_r + 1'b1 : passed_r;

  always_comb begin
    stat             = '0;
    stat.scan_needed = filt_eff && (ref_count_r != '0);
    stat.scan_done   = (hit_r || (scan_idx_r >= ref_count_r)) && !rd_vld_r && !sq_vld_r;
    stat.hit         = hit_r;
    stat.out_free    = out_free;
  end

  // configuration and frame bookkeeping
  // incoming and passed counters and overflow flag are already clear whenever no frame is open
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= THR_RESET;
      ref_bank_r   <= 1'b0;
      ref_count_r  <= '0;
      inc_count_r  <= '0;
      passed_r     <= '0;
      ref_valid_r  <= 1'b0;
      ref_frame_r  <= '0;
      frame_open_r <= 1'b0;
      filt_r       <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
      if (cmd.accept) begin
        if (!frame_open_r) begin
          frame_open_r <= 1'b1;
          filt_r       <= filt_eff;
          ref_frame_r  <= FRAME_W'(in_frame_id);
        end
        if (in_kind == KIND_POINT) begin
          if (store_ok) begin
            inc_count_r <= inc_eff + 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
        end
      end
      if (cmd.emit_keep) begin
        passed_r <= passed_nxt;
      end
      if (cmd.emit_sum) begin
        ref_bank_r   <= ~ref_bank_r;
        ref_count_r  <= inc_count_r;
        ref_valid_r  <= 1'b1;
        frame_open_r <= 1'b0;
        filt_r       <= 1'b0;
        inc_count_r  <= '0;
        passed_r     <= '0;
        ovf_r        <= 1'b0;
      end
    end
  end

  // point latch and distance pipeline
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pt_x_r  <= in_point_x;
      pt_y_r  <= in_point_y;
      pt_z_r  <= in_point_z;
      limit_r <= LIMIT_W'(thr_r) * LIMIT_W'(thr_r);
    end
    sqx_r <= px[SQ_W-1:0];
    sqy_r <= py[SQ_W-1:0];
    sqz_r <= pz[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
      sq_vld_r   <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      sq_vld_r <= rd_vld_r;
      if (cmd.accept) begin
        scan_idx_r <= '0;
        hit_r      <= 1'b0;
      end else begin
        if (issue) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (sq_vld_r && (dist_sum < SUM_W'(limit_r))) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_keep || cmd.emit_sum) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_keep) begin
      out_sum_r <= 1'b0;
      out_x_r   <= pt_x_r;
      out_y_r   <= pt_y_r;
      out_z_r   <= pt_z_r;
      out_cnt_r <= '0;
      out_ovf_r <= 1'b0;
    end else if (cmd.emit_sum) begin
      out_sum_r <= 1'b1;
      out_x_r   <= '0;
      out_y_r   <= '0;
      out_z_r   <= '0;
      out_cnt_r <= passed_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_summary = out_sum_r;
  assign out_kept_x     = out_x_r;
  assign out_kept_y     = out_y_r;
  assign out_kept_z     = out_z_r;
  assign out_kept_count = out_cnt_r;
  assign out_overflow   = out_ovf_r;
  assign out_last       = out_sum_r;

endmodule

[rtl/temporal_point_cloud_radius_filter_top.sv]
// channel  dir  handshake           payload
// in_      in   in_valid/in_stall   kind, frame_id, point_x/y/z
// out_     out  out_valid/out_stall is_summary, kept_x/y/z, kept_count, overflow, last
// cfg_     in   cfg_valid/cfg_ready data (distance threshold)
//
// a point with no reference to scan is taken without a scan
// a scan: an accept, one ram read per reference point up to the first match
// (at most 1024, plus up to 2 reads already issued), the ram read register,
// the square registers and a compare into hit_r; a kept point then loads the output
// register, as does an end of frame summary; a result waits while it is stalled
// synchronous active-low reset clears all control state; the store needs no clearing
module temporal_point_cloud_radius_filter_top
  import tprf_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [THR_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic signed [FRAME_W-1:0]    in_frame_id,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_is_summary,
  output logic signed [COORD_BITS-1:0] out_kept_x,
  output logic signed [COORD_BITS-1:0] out_kept_y,
  output logic signed [COORD_BITS-1:0] out_kept_z,
  output logic [KEPT_W-1:0]            out_kept_count,
  output logic                         out_overflow,
  output logic                         out_last
);

  tprf_cmd_t  cmd;
  tprf_stat_t stat;

  assign cfg_ready = 1'b1;

  tprf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tprf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .in_kind         (in_kind),
    .in_frame_id     (in_frame_id),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_is_summary  (out_is_summary),
    .out_kept_x      (out_kept_x),
    .out_kept_y      (out_kept_y),
    .out_kept_z      (out_kept_z),
    .out_kept_count  (out_kept_count),
    .out_overflow    (out_overflow),
    .out_last        (out_last)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.emit_keep, cmd.emit_sum}))
    else $error("more than one datapath command at once");

  a_keep_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_keep |-> stat.hit)
    else $error("point emitted without a match");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_keep || cmd.emit_sum) |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  a_accept_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !cmd.scan)
    else $error("item taken during a scan");

endmodule
